FILE: hw/rtl/asc_pkg.sv
// Shared types and constants for the ONC RPC system credential parser.
// No dependencies; used by asc_parser, asc_rsp_fifo and the top level.
package asc_pkg;

   localparam int MAX_CRED_BYTES = 400;
   localparam int OFFSET_W       = $clog2(MAX_CRED_BYTES + 1);
   localparam int MIN_BYTES      = 16;
   localparam logic [31:0] DEFAULT_ID = 32'd1000;
   localparam logic [6:0]  GROUPS_SAT = 7'd127;

   // result kinds
   localparam logic [1:0] WHAT_NAME    = 2'd0;
   localparam logic [1:0] WHAT_GROUP   = 2'd1;
   localparam logic [1:0] WHAT_SUMMARY = 2'd2;

   // summary status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_SHORT      = 3'd1;
   localparam logic [2:0] STATUS_NAME_PAST  = 3'd2;
   localparam logic [2:0] STATUS_FIELD_PAST = 3'd3;
   localparam logic [2:0] STATUS_TOO_LONG   = 3'd4;

   // field phases
   localparam logic [3:0] PH_STAMP  = 4'd0;
   localparam logic [3:0] PH_NLEN   = 4'd1;
   localparam logic [3:0] PH_NAME   = 4'd2;
   localparam logic [3:0] PH_PAD    = 4'd3;
   localparam logic [3:0] PH_UID    = 4'd4;
   localparam logic [3:0] PH_GID    = 4'd5;
   localparam logic [3:0] PH_CNT    = 4'd6;
   localparam logic [3:0] PH_GROUPS = 4'd7;
   localparam logic [3:0] PH_TAIL   = 4'd8;
   localparam logic [3:0] PH_OVER   = 4'd9;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  what;
      logic [31:0] value;
      logic [2:0]  status;
      logic        defaulted;
      logic [31:0] stamp;
      logic [31:0] user_id;
      logic [31:0] group_id;
      logic [31:0] name_length;
      logic [6:0]  group_count;
      logic        final_result;
   } result_type;

   // results produced by one transaction, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } step_out_type;

endpackage

FILE: hw/rtl/auth_sys_credential_parser.sv
// ONC RPC system credential body parser, top level.
// Byte input channel (req_*) with valid/ready, result channel (rsp_*) with
// valid/ready. Each req transaction carries one body byte, or an empty-body
// mark (req_no_data). Name bytes and complete group ids come out as they
// are parsed; the byte marked req_last also yields a summary transaction
// (rsp_final_result = 1) with status, stamp, ids, name length and count.
// An empty mark yields group id 1000 and a defaulted summary.
// A req byte is held in the input register, then the parser writes its
// results into the result queue, whose head drives rsp_*.
// Throughput: one byte per cycle while the queue has room for two results.
// A transaction makes at most two results and the result port drains one
// per cycle, so bytes that make two results (final name or group byte,
// empty mark) fill the queue, and once it holds three results the held
// byte waits. The four-entry result queue sets this.
// Reset clears the parser to the start of a body and empties the queue;
// payload storage is not cleared. When the receiver holds rsp_ready low the
// queue fills and req_ready drops once fewer than two entries are free.
// Depends on asc_pkg, asc_parser and asc_rsp_fifo.
module auth_sys_credential_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic        req_no_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_what,
   output logic [31:0] rsp_value,
   output logic [2:0]  rsp_status,
   output logic        rsp_defaulted,
   output logic [31:0] rsp_stamp,
   output logic [31:0] rsp_user_id,
   output logic [31:0] rsp_group_id,
   output logic [31:0] rsp_name_length,
   output logic [6:0]  rsp_group_count,
   output logic        rsp_final_result
);
   import asc_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   logic               in_none_ff;
   logic               advance;
   logic               req_take;
   logic               pop;
   step_out_type       step_out;
   result_type         head;
   logic               not_empty;
   logic [LEVEL_W-1:0] level;
   logic [1:0]         push_count;

   // room for two results is needed before the held byte can be parsed
   assign advance     = in_valid_ff && (level <= LEVEL_W'(FIFO_DEPTH - 2));
   assign req_ready   = !in_valid_ff || advance;
   assign req_take    = req_valid && req_ready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign push_count  = advance ? step_out.count : 2'd0;
   assign pop         = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last;
         in_none_ff <= req_no_data;
      end
   end

   asc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last      (in_last_ff),
      .no_data   (in_none_ff),
      .results   (step_out)
   );

   asc_rsp_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (step_out.first),
      .push_second (step_out.second),
      .pop         (pop),
      .head        (head),
      .not_empty   (not_empty),
      .level       (level)
   );

   assign rsp_valid        = not_empty;
   assign rsp_what         = head.what;
   assign rsp_value        = head.value;
   assign rsp_status       = head.status;
   assign rsp_defaulted    = head.defaulted;
   assign rsp_stamp        = head.stamp;
   assign rsp_user_id      = head.user_id;
   assign rsp_group_id     = head.group_id;
   assign rsp_name_length  = head.name_length;
   assign rsp_group_count  = head.group_count;
   assign rsp_final_result = head.final_result;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= LEVEL_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_advance_room: assert property (@(posedge clock) disable iff (reset)
      advance |=> level <= LEVEL_W'(FIFO_DEPTH))
      else $error("parser advanced without queue room");

   a_final_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_result |-> rsp_what == WHAT_SUMMARY)
      else $error("final result is not a summary");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("queue or input stage not cleared by reset");

endmodule

FILE: hw/rtl/asc_parser.sv
// Field state machine of the credential parser: takes one byte per step
// and produces up to two results. Depends on asc_pkg.
module asc_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data_byte,
   input  logic                 last,
   input  logic                 no_data,
   output asc_pkg::step_out_type results
);
   import asc_pkg::*;

   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [3:0]          phase_ff, phase_in, phase_now;
   logic [31:0]         shift_ff, shift_in;
   logic [31:0]         stamp_ff, stamp_in;
   logic [31:0]         nlen_ff, nlen_in;
   logic [31:0]         bytes_left_ff, bytes_left_in;
   logic [31:0]         uid_ff, uid_in;
   logic [31:0]         gid_ff, gid_in;
   logic [31:0]         groups_left_ff, groups_left_in;
   logic [6:0]          seen_ff, seen_in;
   logic                whole;
   logic                emit_item;
   result_type          item;
   result_type          summary;
   logic [2:0]          status;

   always_comb begin
      phase_now = (offset_ff >= OFFSET_W'(MAX_CRED_BYTES)) ? PH_OVER : phase_ff;
      offset_in      = offset_ff;
      phase_in       = phase_now;
      shift_in       = shift_ff;
      stamp_in       = stamp_ff;
      nlen_in        = nlen_ff;
      bytes_left_in  = bytes_left_ff;
      uid_in         = uid_ff;
      gid_in         = gid_ff;
      groups_left_in = groups_left_ff;
      seen_in        = seen_ff;
      whole          = (offset_ff[1:0] == 2'b11);
      emit_item      = 1'b0;
      item           = '0;

      if (phase_now != PH_OVER) begin
         offset_in = offset_ff + OFFSET_W'(1);
         shift_in  = {shift_ff[23:0], data_byte};
         unique case (phase_now)
            PH_STAMP: begin
               if (whole) begin
                  stamp_in = shift_in;
                  phase_in = PH_NLEN;
               end
            end
            PH_NLEN: begin
               if (whole) begin
                  nlen_in       = shift_in;
                  bytes_left_in = shift_in;
                  phase_in      = (shift_in != 32'd0) ? PH_NAME : PH_UID;
               end
            end
            PH_NAME: begin
               emit_item     = 1'b1;
               item.what     = WHAT_NAME;
               item.value    = {24'd0, data_byte};
               bytes_left_in = bytes_left_ff - 32'd1;
               if (bytes_left_in == 32'd0) begin
                  phase_in = (offset_in[1:0] != 2'b00) ? PH_PAD : PH_UID;
               end
            end
            PH_PAD: begin
               if (offset_in[1:0] == 2'b00) begin
                  phase_in = PH_UID;
               end
            end
            PH_UID: begin
               if (whole) begin
                  uid_in   = shift_in;
                  phase_in = PH_GID;
               end
            end
            PH_GID: begin
               if (whole) begin
                  gid_in   = shift_in;
                  phase_in = PH_CNT;
               end
            end
            PH_CNT: begin
               if (whole) begin
                  groups_left_in = shift_in;
                  phase_in       = (shift_in != 32'd0) ? PH_GROUPS : PH_TAIL;
               end
            end
            PH_GROUPS: begin
               if (whole) begin
                  emit_item      = 1'b1;
                  item.what      = WHAT_GROUP;
                  item.value     = shift_in;
                  groups_left_in = groups_left_ff - 32'd1;
                  if (seen_ff != GROUPS_SAT) begin
                     seen_in = seen_ff + 7'd1;
                  end
                  if (groups_left_in == 32'd0) begin
                     phase_in = PH_TAIL;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      priority if (phase_in == PH_OVER) begin
         status = STATUS_TOO_LONG;
      end else if (offset_in < OFFSET_W'(MIN_BYTES)) begin
         status = STATUS_SHORT;
      end else if (phase_in == PH_NAME || phase_in == PH_PAD) begin
         status = STATUS_NAME_PAST;
      end else if (phase_in == PH_STAMP || phase_in == PH_NLEN || phase_in == PH_UID ||
                   phase_in == PH_GID || phase_in == PH_CNT) begin
         status = STATUS_FIELD_PAST;
      end else begin
         status = STATUS_OK;
      end

      summary              = '0;
      summary.what         = WHAT_SUMMARY;
      summary.status       = status;
      summary.stamp        = stamp_in;
      summary.user_id      = uid_in;
      summary.group_id     = gid_in;
      summary.name_length  = nlen_in;
      summary.group_count  = seen_in;
      summary.final_result = 1'b1;

      results = '0;
      if (no_data) begin
         // empty body: default identity, any body in progress is dropped
         results.count              = 2'd2;
         results.first.what         = WHAT_GROUP;
         results.first.value        = DEFAULT_ID;
         results.second.what        = WHAT_SUMMARY;
         results.second.defaulted   = 1'b1;
         results.second.user_id     = DEFAULT_ID;
         results.second.group_id    = DEFAULT_ID;
         results.second.group_count = 7'd1;
         results.second.final_result = 1'b1;
      end else if (emit_item && last) begin
         results.count  = 2'd2;
         results.first  = item;
         results.second = summary;
      end else if (emit_item) begin
         results.count = 2'd1;
         results.first = item;
      end else if (last) begin
         results.count = 2'd1;
         results.first = summary;
      end

      // start a fresh body after the final byte or an empty mark
      if (no_data || last) begin
         offset_in      = '0;
         phase_in       = PH_STAMP;
         shift_in       = '0;
         stamp_in       = '0;
         nlen_in        = '0;
         bytes_left_in  = '0;
         uid_in         = '0;
         gid_in         = '0;
         groups_left_in = '0;
         seen_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff      <= '0;
         phase_ff       <= PH_STAMP;
         shift_ff       <= '0;
         stamp_ff       <= '0;
         nlen_ff        <= '0;
         bytes_left_ff  <= '0;
         uid_ff         <= '0;
         gid_ff         <= '0;
         groups_left_ff <= '0;
         seen_ff        <= '0;
      end else if (step) begin
         offset_ff      <= offset_in;
         phase_ff       <= phase_in;
         shift_ff       <= shift_in;
         stamp_ff       <= stamp_in;
         nlen_ff        <= nlen_in;
         bytes_left_ff  <= bytes_left_in;
         uid_ff         <= uid_in;
         gid_ff         <= gid_in;
         groups_left_ff <= groups_left_in;
         seen_ff        <= seen_in;
      end
   end

endmodule

FILE: hw/rtl/asc_rsp_fifo.sv
// Result queue of the credential parser: takes up to two results per
// cycle, hands out one. Depends on asc_pkg.
module asc_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    push_count,
   input  asc_pkg::result_type           push_first,
   input  asc_pkg::result_type           push_second,
   input  logic                          pop,
   output asc_pkg::result_type           head,
   output logic                          not_empty,
   output logic [asc_pkg::LEVEL_W-1:0]   level
);
   import asc_pkg::*;

   result_type         entries [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [PTR_W-1:0]   wr_next;

   always_comb begin
      wr_next   = wr_ptr_ff + PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      level_in  = level_ff + LEVEL_W'(push_count) - LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entries[wr_next] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head      = entries[rd_ptr_ff];
   assign not_empty = (level_ff != '0);
   assign level     = level_ff;

endmodule
